@@ rtl/svpwm_compare_calc_defines.svh @@
// Assertion macros for the SVPWM compare calculator.
// Each check runs on the rising edge of clk.
`ifndef SVPWM_COMPARE_CALC_DEFINES_SVH
`define SVPWM_COMPARE_CALC_DEFINES_SVH

// Check that is disabled while rst is high.
`define SVPWM_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also runs during reset.
`define SVPWM_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/svpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared widths, constants and beat types of the SVPWM compare calculator.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  localparam int FRAC_BITS  = 18;
  localparam int VOLT_W     = 16;
  localparam int BUS_W      = 15;
  localparam int PER_W      = 16;
  localparam int Q_W        = FRAC_BITS + 1;   // unsaturated quotient bits
  localparam int DIV_STAGES = Q_W + 1;         // prep stage + one stage per bit
  localparam int RAT_W      = Q_W + 2;         // signed ratio, +-2.0 inclusive
  localparam int K_W        = 19;

  // 1/sqrt3 and 2/sqrt3, rounded to 18 fractional bits
  localparam logic [K_W-1:0] K1 = K_W'(151349);
  localparam logic [K_W-1:0] K2 = K_W'(302698);

  localparam logic [PER_W-1:0] PER_RESET = PER_W'(4096);

  typedef struct packed {
    logic signed [VOLT_W-1:0] v_alpha;
    logic signed [VOLT_W-1:0] v_beta;
    logic [BUS_W-1:0]         v_bus;
  } item_t;

  typedef struct packed {
    logic [PER_W-1:0] duty_u;
    logic [PER_W-1:0] duty_v;
    logic [PER_W-1:0] duty_w;
  } result_t;

endpackage

@@ rtl/svpwm_div.sv @@
// ----------------------------------------------------------------------------
// svpwm_div
// Pipelined restoring divider: num / den with FRAC_BITS fraction bits,
// truncated toward zero, saturated to +-2.0. One quotient bit per stage.
// ----------------------------------------------------------------------------
module svpwm_div
  import svpwm_pkg::*;
(
  input  logic                     clk,
  input  logic [DIV_STAGES-1:0]    en,
  input  logic signed [VOLT_W-1:0] num,
  input  logic [BUS_W-1:0]         den,
  output logic signed [RAT_W-1:0]  ratio
);

  logic [VOLT_W-1:0] rem [DIV_STAGES];
  logic [Q_W-1:0]    quo [DIV_STAGES];
  logic [BUS_W-1:0]  dv  [DIV_STAGES];
  logic              ng  [DIV_STAGES];
  logic              st  [DIV_STAGES];

  logic [VOLT_W-1:0] mag;
  logic              sat0;
  logic [Q_W:0]      mq;
  logic [RAT_W-1:0]  mq_x;

  assign mag  = num[VOLT_W-1] ? VOLT_W'(-num) : VOLT_W'(num);
  // |num| >= 2*den means quotient >= 2.0 (also covers den == 0)
  assign sat0 = (mag != '0) && ({1'b0, mag} >= {1'b0, den, 1'b0});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0] <= mag;
      quo[0] <= '0;
      // zero numerator: nonzero divisor keeps every quotient bit clear
      dv[0]  <= (mag == '0) ? '1 : den;
      ng[0]  <= num[VOLT_W-1];
      st[0]  <= sat0;
    end
  end

  for (genvar j = 1; j < DIV_STAGES; j++) begin : g_step
    logic [VOLT_W:0] trial;
    logic            ge;
    logic [Q_W-1:0]  qn;

    always_comb begin
      // first step compares the bare magnitude, later ones the doubled rest
      trial = (j == 1) ? {1'b0, rem[j-1]} : {rem[j-1], 1'b0};
      ge    = trial >= {2'b00, dv[j-1]};
      qn    = quo[j-1];
      qn[Q_W-j] = ge;
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j] <= ge ? VOLT_W'(trial - {2'b00, dv[j-1]}) : trial[VOLT_W-1:0];
        quo[j] <= qn;
        dv[j]  <= dv[j-1];
        ng[j]  <= ng[j-1];
        st[j]  <= st[j-1];
      end
    end
  end

  assign mq    = st[DIV_STAGES-1] ? {1'b1, {Q_W{1'b0}}} : {1'b0, quo[DIV_STAGES-1]};
  assign mq_x  = {1'b0, mq};
  assign ratio = ng[DIV_STAGES-1] ? $signed(-mq_x) : $signed(mq_x);

endmodule

@@ rtl/svpwm_compare_calc.sv @@
// Throughput: one item per cycle while result_stall is low; 27 register stages,
//   set by the 20-stage divider (prep plus one quotient bit per stage) plus
//   multiply and phase stages.
// Stalls close bubbles stage by stage; a waiting result holds the last stage.
// Reset (rst, synchronous): all valid bits clear, the period returns to 4096.
// ----------------------------------------------------------------------------
// svpwm_compare_calc
// Center-aligned space vector PWM compare calculator: normalizes alpha/beta
// by the bus voltage, finds the sector, forms the active times scaled by
// the carrier period and gives clamped compare values for phases U, V and W.
// ----------------------------------------------------------------------------
`include "svpwm_compare_calc_defines.svh"

module svpwm_compare_calc
  import svpwm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // item channel
  input  logic             item_valid,
  output logic             item_stall,
  input  item_t            item,
  // result channel
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result,
  // period register write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [PER_W-1:0] cfg_data
);

  // stage map
  localparam int S_MUL = DIV_STAGES;   // |b| * K products
  localparam int S_KB  = S_MUL + 1;    // K*b truncated
  localparam int S_SEC = S_KB + 1;     // sector, x1/x2
  localparam int S_TP  = S_SEC + 1;    // |x| * period
  localparam int S_T   = S_TP + 1;     // t1/t2
  localparam int S_H   = S_T + 1;      // half sum
  localparam int S_OUT = S_H + 1;      // phases, clamp, result beat
  localparam int N_ST  = S_OUT + 1;

  localparam int P_W   = Q_W + 1 + K_W;           // |b| * K
  localparam int XW    = RAT_W + 1;               // x1/x2, signed
  localparam int TP_W  = XW - 1 + PER_W;          // |x| * period
  localparam int T_W   = TP_W - FRAC_BITS + 1;    // t, signed
  localparam int SUM_W = T_W + 2;
  localparam int PH_W  = SUM_W + 2;

  localparam logic [2:0] SEC1 = 3'd1;
  localparam logic [2:0] SEC2 = 3'd2;
  localparam logic [2:0] SEC3 = 3'd3;
  localparam logic [2:0] SEC4 = 3'd4;
  localparam logic [2:0] SEC5 = 3'd5;
  localparam logic [2:0] SEC6 = 3'd6;

  function automatic logic [PER_W-1:0] clamp_ph(input logic signed [PH_W-1:0] v,
                                                input logic [PER_W-1:0] p);
    logic signed [PH_W-1:0] ps;
    ps = $signed({{(PH_W-PER_W){1'b0}}, p});
    if (v < 0)       return '0;
    else if (v > ps) return p;
    else             return v[PER_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Period register. Writes land only while the pipeline is empty.
  // --------------------------------------------------------------------------
  logic [PER_W-1:0] per;
  logic [N_ST-1:0]  vld;

  assign cfg_ready = !(|vld);

  always_ff @(posedge clk) begin
    if (rst) begin
      per <= PER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      per <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // Valid chain. A stage loads when it is empty or its successor moves on,
  // so bubbles collapse under a stalled output.
  // --------------------------------------------------------------------------
  logic [N_ST-1:0] en;

  always_comb begin
    en[N_ST-1] = !vld[N_ST-1] || !result_stall;
    for (int k = N_ST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= item_valid;
      for (int k = 1; k < N_ST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign item_stall   = !en[0];
  assign result_valid = vld[N_ST-1];

  // --------------------------------------------------------------------------
  // Ratios a = v_alpha / v_bus, b = v_beta / v_bus (stages 0 .. S_MUL-1)
  // --------------------------------------------------------------------------
  logic signed [RAT_W-1:0] ra;
  logic signed [RAT_W-1:0] rb;

  svpwm_div u_div_a (
    .clk   (clk),
    .en    (en[DIV_STAGES-1:0]),
    .num   (item.v_alpha),
    .den   (item.v_bus),
    .ratio (ra)
  );

  svpwm_div u_div_b (
    .clk   (clk),
    .en    (en[DIV_STAGES-1:0]),
    .num   (item.v_beta),
    .den   (item.v_bus),
    .ratio (rb)
  );

  // --------------------------------------------------------------------------
  // S_MUL: |b| * K1, |b| * K2. Sign taken from the ratio, so -0 counts as 0.
  // --------------------------------------------------------------------------
  logic [Q_W:0]            bmag;
  logic signed [RAT_W-1:0] a_m;
  logic                    bneg_m;
  logic [P_W-1:0]          pk1;
  logic [P_W-1:0]          pk2;

  assign bmag = rb[RAT_W-1] ? (Q_W+1)'(-rb) : (Q_W+1)'(rb);

  always_ff @(posedge clk) begin
    if (en[S_MUL]) begin
      a_m    <= ra;
      bneg_m <= rb[RAT_W-1];
      pk1    <= P_W'(bmag) * P_W'(K1);
      pk2    <= P_W'(bmag) * P_W'(K2);
    end
  end

  // --------------------------------------------------------------------------
  // S_KB: truncate toward zero back to FRAC_BITS
  // --------------------------------------------------------------------------
  logic signed [RAT_W-1:0] a_k, kb_k, k2b_k;
  logic                    bneg_k;
  logic [RAT_W-1:0]        kb_mag, k2b_mag;

  assign kb_mag  = {1'b0, pk1[FRAC_BITS +: Q_W+1]};
  assign k2b_mag = {1'b0, pk2[FRAC_BITS +: Q_W+1]};

  always_ff @(posedge clk) begin
    if (en[S_KB]) begin
      a_k    <= a_m;
      bneg_k <= bneg_m;
      kb_k   <= bneg_m ? $signed(-kb_mag)  : $signed(kb_mag);
      k2b_k  <= bneg_m ? $signed(-k2b_mag) : $signed(k2b_mag);
    end
  end

  // --------------------------------------------------------------------------
  // S_SEC: sector from signs and a vs +-K1*b, then the two vector ratios
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] ax, kx, k2x;
  logic [2:0]           sec_n;
  logic signed [XW-1:0] x1_n, x2_n;
  logic [2:0]           sec_s;
  logic signed [XW-1:0] x1_s, x2_s;

  assign ax  = XW'(a_k);
  assign kx  = XW'(kb_k);
  assign k2x = XW'(k2b_k);

  always_comb begin
    if (!bneg_k) begin
      if (!ax[XW-1]) sec_n = (kx > ax)  ? SEC2 : SEC1;
      else           sec_n = (-kx > ax) ? SEC3 : SEC2;
    end else begin
      if (!ax[XW-1]) sec_n = (-kx > ax) ? SEC5 : SEC6;
      else           sec_n = (kx > ax)  ? SEC4 : SEC5;
    end
    unique case (sec_n)
      SEC1:    begin x1_n = ax - kx;  x2_n = k2x;      end
      SEC2:    begin x1_n = ax + kx;  x2_n = kx - ax;  end
      SEC3:    begin x1_n = k2x;      x2_n = -ax - kx; end
      SEC4:    begin x1_n = kx - ax;  x2_n = -k2x;     end
      SEC5:    begin x1_n = -ax - kx; x2_n = ax - kx;  end
      default: begin x1_n = -k2x;     x2_n = ax + kx;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[S_SEC]) begin
      sec_s <= sec_n;
      x1_s  <= x1_n;
      x2_s  <= x2_n;
    end
  end

  // --------------------------------------------------------------------------
  // S_TP: |x| * period
  // --------------------------------------------------------------------------
  logic [XW-2:0]   x1_mag, x2_mag;
  logic [TP_W-1:0] tp1, tp2;
  logic            n1_p, n2_p;
  logic [2:0]      sec_p;

  assign x1_mag = x1_s[XW-1] ? (XW-1)'(-x1_s) : (XW-1)'(x1_s);
  assign x2_mag = x2_s[XW-1] ? (XW-1)'(-x2_s) : (XW-1)'(x2_s);

  always_ff @(posedge clk) begin
    if (en[S_TP]) begin
      sec_p <= sec_s;
      n1_p  <= x1_s[XW-1];
      n2_p  <= x2_s[XW-1];
      tp1   <= TP_W'(x1_mag) * TP_W'(per);
      tp2   <= TP_W'(x2_mag) * TP_W'(per);
    end
  end

  // --------------------------------------------------------------------------
  // S_T: times, truncated toward zero
  // --------------------------------------------------------------------------
  logic [T_W-1:0]        t1_mag, t2_mag;
  logic signed [T_W-1:0] t1_t, t2_t;
  logic [2:0]            sec_t;

  assign t1_mag = {1'b0, tp1[TP_W-1:FRAC_BITS]};
  assign t2_mag = {1'b0, tp2[TP_W-1:FRAC_BITS]};

  always_ff @(posedge clk) begin
    if (en[S_T]) begin
      sec_t <= sec_p;
      t1_t  <= n1_p ? $signed(-t1_mag) : $signed(t1_mag);
      t2_t  <= n2_p ? $signed(-t2_mag) : $signed(t2_mag);
    end
  end

  // --------------------------------------------------------------------------
  // S_H: half of (period + t1 + t2), rounded toward minus infinity
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_n;
  logic signed [SUM_W-1:0] h_h;
  logic signed [T_W-1:0]   t1_h, t2_h;
  logic [2:0]              sec_h;

  assign sum_n = $signed({{(SUM_W-PER_W){1'b0}}, per}) + SUM_W'(t1_t) + SUM_W'(t2_t);

  always_ff @(posedge clk) begin
    if (en[S_H]) begin
      sec_h <= sec_t;
      t1_h  <= t1_t;
      t2_h  <= t2_t;
      h_h   <= sum_n >>> 1;
    end
  end

  // --------------------------------------------------------------------------
  // S_OUT: phase chain per sector, clamp to [0, period], result register
  // --------------------------------------------------------------------------
  logic signed [PH_W-1:0] hp, t1p, t2p;
  logic signed [PH_W-1:0] pu, pv, pw;

  assign hp  = PH_W'(h_h);
  assign t1p = PH_W'(t1_h);
  assign t2p = PH_W'(t2_h);

  always_comb begin
    unique case (sec_h)
      SEC1:    begin pu = hp;  pv = pu - t1p; pw = pv - t2p; end
      SEC2:    begin pv = hp;  pu = pv - t2p; pw = pu - t1p; end
      SEC3:    begin pv = hp;  pw = pv - t1p; pu = pw - t2p; end
      SEC4:    begin pw = hp;  pv = pw - t2p; pu = pv - t1p; end
      SEC5:    begin pw = hp;  pu = pw - t1p; pv = pu - t2p; end
      default: begin pu = hp;  pw = pu - t2p; pv = pw - t1p; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      result.duty_u <= clamp_ph(pu, per);
      result.duty_v <= clamp_ph(pv, per);
      result.duty_w <= clamp_ph(pw, per);
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `SVPWM_CHECK(a_duty_in_range, result_valid |-> (result.duty_u <= per) && (result.duty_v <= per) && (result.duty_w <= per), "duty above carrier period")
  `SVPWM_CHECK(a_stall_only_full, item_stall |-> vld[0] && vld[N_ST-1] && result_stall, "input stalled with room in pipe")
  `SVPWM_CHECK_RST(a_reset_clears, rst |=> !result_valid, "result beat right after reset")

endmodule

@@ test/svpwm_compare_calc_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_compare_calc_test
// Drives alpha/beta/bus beats and period writes into the compare calculator
// and checks every result beat against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module svpwm_compare_calc_test;
  import svpwm_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_stall;
  item_t            item = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  result_t          result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [PER_W-1:0] cfg_data = '0;

  // period shadow used by the predictor
  logic [PER_W-1:0] period_q = PER_RESET;
  result_t          duty_expected[$];
  int               errors = 0;
  longint           cycles = 0;
  bit               quiet = 1'b0;  // no idling in the last part

  localparam longint CYCLE_LIMIT = 400000;
  localparam int     TAIL_CYCLES = 60;

  svpwm_compare_calc i_dut (
    .clk, .rst, .item_valid, .item_stall, .item,
    .result_valid, .result_stall, .result,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Q18 ratio: truncated toward zero, saturated to +-2, zero bus saturates.
  function automatic longint norm_ratio(longint num, longint den);
    longint mag, q, lim;
    mag = (num < 0) ? -num : num;
    lim = longint'(2) << FRAC_BITS;
    if (mag == 0) return 0;
    q = (den == 0) ? lim : (mag << FRAC_BITS) / den;
    if (q > lim) q = lim;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint k_mul(longint k, longint b);
    longint p, mag;
    p = k * b;
    mag = ((p < 0) ? -p : p) >>> FRAC_BITS;
    return (p < 0) ? -mag : mag;
  endfunction

  function automatic longint on_time(longint x, longint per);
    longint mag, t;
    mag = (x < 0) ? -x : x;
    t = (mag >>> FRAC_BITS) * per + (((mag & ((longint'(1) << FRAC_BITS) - 1)) * per)
        >>> FRAC_BITS);
    return (x < 0) ? -t : t;
  endfunction

  function automatic logic [PER_W-1:0] clamp_duty(longint v, longint per);
    if (v < 0) return '0;
    if (v > per) return per[PER_W-1:0];
    return v[PER_W-1:0];
  endfunction

  function automatic result_t predict_duty(item_t it, logic [PER_W-1:0] period);
    longint per, a, b, kb, k2b, x1, x2, t1, t2, sum, h, u, v, w;
    int sector;
    result_t r;
    per = period;
    a = norm_ratio(longint'(it.v_alpha), longint'(it.v_bus));
    b = norm_ratio(longint'(it.v_beta), longint'(it.v_bus));
    kb = k_mul(longint'(K1), b);
    k2b = k_mul(longint'(K2), b);
    if (b >= 0) sector = (a >= 0) ? ((kb > a) ? 2 : 1) : ((-kb > a) ? 3 : 2);
    else        sector = (a >= 0) ? ((-kb > a) ? 5 : 6) : ((kb > a) ? 4 : 5);
    case (sector)
      1: begin x1 = a - kb;  x2 = k2b;     end
      2: begin x1 = a + kb;  x2 = kb - a;  end
      3: begin x1 = k2b;     x2 = -a - kb; end
      4: begin x1 = kb - a;  x2 = -k2b;    end
      5: begin x1 = -a - kb; x2 = a - kb;  end
      default: begin x1 = -k2b; x2 = a + kb; end
    endcase
    t1 = on_time(x1, per);
    t2 = on_time(x2, per);
    sum = per + t1 + t2;
    h = sum >>> 1;  // floor
    case (sector)
      1: begin u = h; v = u - t1; w = v - t2; end
      2: begin v = h; u = v - t2; w = u - t1; end
      3: begin v = h; w = v - t1; u = w - t2; end
      4: begin w = h; v = w - t2; u = v - t1; end
      5: begin w = h; u = w - t1; v = u - t2; end
      default: begin u = h; w = u - t2; v = w - t1; end
    endcase
    r.duty_u = clamp_duty(u, per);
    r.duty_v = clamp_duty(v, per);
    r.duty_w = clamp_duty(w, per);
    return r;
  endfunction

  // Receiver: random stall bursts, check each accepted beat.
  initial begin : result_side
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        if (duty_expected.size() == 0) begin
          $display("%0t unexpected result beat: actual %h", $time, result);
          errors++;
        end else begin
          result_t e;
          e = duty_expected.pop_front();
          if (result.duty_u !== e.duty_u)
            $display("%0t duty_u expected %0d actual %0d", $time, e.duty_u, result.duty_u);
          if (result.duty_v !== e.duty_v)
            $display("%0t duty_v expected %0d actual %0d", $time, e.duty_v, result.duty_v);
          if (result.duty_w !== e.duty_w)
            $display("%0t duty_w expected %0d actual %0d", $time, e.duty_w, result.duty_w);
          if (result !== e) errors++;
        end
      end
      if (burst > 0) burst--;
      else if (!quiet && $urandom_range(0, 9) == 0) burst = $urandom_range(1, 14);
      result_stall <= (burst > 0) && !quiet;
    end
  end

  // Send one input beat; prediction is taken at the accept edge.
  // Valid stays high between back-to-back beats; idle gaps and drain drop it.
  task automatic send_voltage(logic signed [15:0] va, logic signed [15:0] vb,
                              logic [BUS_W-1:0] bus);
    item_t it;
    it.v_alpha = va;
    it.v_beta = vb;
    it.v_bus = bus;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    duty_expected.push_back(predict_duty(it, period_q));
  endtask

  task automatic drain;
    item_valid <= 1'b0;
    while (duty_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(logic [PER_W-1:0] per);
    drain();
    cfg_data <= per;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    period_q = per;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_voltage;
    logic signed [15:0] va, vb;
    logic [BUS_W-1:0] bus;
    va = 16'($urandom);
    vb = 16'($urandom);
    case ($urandom_range(0, 3))
      0: bus = BUS_W'($urandom);
      1: bus = BUS_W'($urandom_range(1, 64));
      default: begin
        // magnitudes inside the hexagon dominate
        bus = BUS_W'($urandom_range(1000, 32767));
        va = $signed(va) % $signed({1'b0, bus});
        vb = $signed(vb) % $signed({1'b0, bus});
      end
    endcase
    if ($urandom_range(0, 40) == 0) bus = '0;
    send_voltage(va, vb, bus);
  endtask

  task automatic test_directed;
    send_voltage(0, 0, 1000);
    send_voltage(16'sh7FFF, 0, 1);
    send_voltage(16'sh8000, 0, 1);
    send_voltage(0, 16'sh7FFF, 32767);
    send_voltage(0, 16'sh8000, 32767);
    send_voltage(16'sh8000, 16'sh8000, 15'h7FFF);
    send_voltage(16'sh7FFF, 16'sh7FFF, 15'h7FFF);
    send_voltage(100, 0, 0);
    send_voltage(-100, 50, 0);
    send_voltage(0, 0, 0);
    // one point in each sector
    send_voltage(800, 200, 1000);
    send_voltage(200, 800, 1000);
    send_voltage(-800, 200, 1000);
    send_voltage(-800, -200, 1000);
    send_voltage(200, -800, 1000);
    send_voltage(800, -200, 1000);
    send_voltage(-1, -1, 15'h7FFF);
  endtask

  task automatic test_period_extremes;
    write_period(16'hFFFF);
    test_directed();
    write_period(16'd1);
    test_directed();
    write_period('0);
    send_voltage(500, -300, 1000);
    send_voltage(16'sh7FFF, 16'sh8000, 3);
  endtask

  task automatic test_random;
    logic [PER_W-1:0] p;
    for (int ph = 0; ph < 5; ph++) begin
      p = (ph == 4) ? PER_RESET : PER_W'($urandom_range(1, 65535));
      write_period(p);
      if (ph == 4) quiet = 1'b1;
      for (int n = 0; n < 90; n++) random_voltage();
    end
  endtask

  initial begin : main
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_period_extremes();
    test_random();
    drain();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ svpwm_compare_calc.f @@
+incdir+rtl
rtl/svpwm_pkg.sv
rtl/svpwm_div.sv
rtl/svpwm_compare_calc.sv
test/svpwm_compare_calc_test.sv
